// ===== design/btmx_pkg.sv =====
package btmx_pkg;

    // Key and count geometry
    localparam int VALUE_BITS    = 16;
    localparam int KEY_W         = 16;
    localparam int KB_W          = $clog2(VALUE_BITS);
    localparam int LVL_W         = $clog2(VALUE_BITS + 1);
    localparam int COUNT_W       = 16;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT = 16'hFFFF;
    localparam int MAX_NODES_DEF = 1024;

    // Item kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_NO_NODE    = 2'd1;
    localparam logic [1:0] ST_ABSENT     = 2'd2;
    localparam logic [1:0] ST_COUNT_FULL = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [KEY_W-1:0] key_value;
    } item_t;

    typedef struct packed {
        logic [KEY_W-1:0] max_xor;
        logic [1:0]       status;
    } result_t;

    typedef struct packed {
        logic shift_in;
        logic shift_out;
    } chain_ctl_t;

endpackage

// ===== design/btmx_ram.sv =====
module btmx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one entry, register the read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/btmx_cell.sv =====
module btmx_cell
    import btmx_pkg::*;
#(
    parameter int REC_W = 8
) (
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic [REC_W-1:0] from_left,
    input  logic [REC_W-1:0] from_right,
    output logic [REC_W-1:0] q
);

    logic [REC_W-1:0] rec_reg;

    // Take the record from the deeper or the shallower neighbor
    always_ff @(posedge clk)
    begin
        if (ctl.shift_in)
        begin
            rec_reg <= from_left;
        end
        else if (ctl.shift_out)
        begin
            rec_reg <= from_right;
        end
    end

    assign q = rec_reg;

endmodule

// ===== design/btmx_chain.sv =====
module btmx_chain
    import btmx_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int REC_W = 8
) (
    input  logic             clk,
    input  chain_ctl_t       ctl,
    input  logic [REC_W-1:0] din,
    output logic [REC_W-1:0] head0,
    output logic [REC_W-1:0] head1
);

    logic [REC_W-1:0] tap [DEPTH];

    // Row of path cells, newest record at position zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [REC_W-1:0] left_d;
        logic [REC_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = din;
        end
        else
        begin : g_mid
            assign left_d = tap[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_inner
            assign right_d = tap[i+1];
        end

        btmx_cell #(.REC_W(REC_W)) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .from_left  (left_d),
            .from_right (right_d),
            .q          (tap[i])
        );
    end

    assign head0 = tap[0];
    assign head1 = tap[1];

endmodule

// ===== design/binary_trie_max_xor_top.sv =====
// Binary trie of 16-bit keys answering maximum-xor queries.
// Input channel: item (kind, key_value) is taken on a rising edge with start
// high and busy low. Kinds: insert, remove, query; the unused kind returns
// zero at once. One result per item: done is high for exactly one cycle with
// result (max_xor, status); the receiver always takes it.
// Sequence (B = 16 key bits, d = depth of the existing path of the key):
//   query and remove walk one trie level per link-memory read, then take an
//   evaluation step and a result step; a remove that finds its key adds B
//   count updates before its result.
//   insert: walk and evaluation, then d count updates along the existing
//   path, then B - d new nodes, each needing a free-stack read and an
//   allocate step, then a leaf link write and the result.
// The walk path is kept in a row of B cells that shift the visited node
// records in during the walk and out again during the count updates.
// One item is processed at a time; busy stays high until done.
// Reset: the trie is empty (root links zero, no nodes in use), ready at once.
// Node memories need no clearing: a node is cleared when it is handed out.
module binary_trie_max_xor_top
    import btmx_pkg::*;
#(
    parameter int MAX_NODES = MAX_NODES_DEF
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int LINK_W = 2 * IDX_W;
    localparam int REC_W  = IDX_W + COUNT_W + LINK_W;
    localparam logic [IDX_W-1:0] NODE_LAST = IDX_W'(MAX_NODES - 1);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WALK     = 4'd1;
    localparam logic [3:0] S_EVAL     = 4'd2;
    localparam logic [3:0] S_INS_CNT  = 4'd3;
    localparam logic [3:0] S_ALLOC_RD = 4'd4;
    localparam logic [3:0] S_ALLOC_WR = 4'd5;
    localparam logic [3:0] S_LEAF     = 4'd6;
    localparam logic [3:0] S_REM_POP  = 4'd7;
    localparam logic [3:0] S_DONE     = 4'd8;

    function automatic logic [IDX_W-1:0] side_of(input logic [LINK_W-1:0] lk,
                                                 input logic side);
        logic [IDX_W-1:0] r;
        r = side ? lk[LINK_W-1:IDX_W] : lk[IDX_W-1:0];
        return r;
    endfunction

    function automatic logic [LINK_W-1:0] set_side(input logic [LINK_W-1:0] lk,
                                                   input logic side,
                                                   input logic [IDX_W-1:0] v);
        logic [LINK_W-1:0] r;
        r = lk;
        if (side)
        begin
            r[LINK_W-1:IDX_W] = v;
        end
        else
        begin
            r[IDX_W-1:0] = v;
        end
        return r;
    endfunction

    logic [3:0]        state_reg, state_next;
    logic [1:0]        kind_reg, kind_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [LINK_W-1:0] root_reg, root_next;
    logic              at_root_reg, at_root_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  npend_reg, npend_next;
    logic [LVL_W-1:0]  cnt_reg, cnt_next;
    logic [LVL_W-1:0]  depth_reg, depth_next;
    logic              sat_reg, sat_next;
    logic [KEY_W-1:0]  res_reg, res_next;
    logic [1:0]        status_reg, status_next;
    logic [IDX_W-1:0]  parent_reg, parent_next;
    logic              proot_reg, proot_next;
    logic [LINK_W-1:0] park_reg, park_next;
    logic [IDX_W-1:0]  ftop_reg, ftop_next;
    logic [IDX_W:0]    nunused_reg, nunused_next;
    logic [IDX_W-1:0]  used_reg, used_next;

    logic              link_we, cnt_we, fs_we;
    logic [IDX_W-1:0]  link_waddr, link_raddr, cnt_waddr, cnt_raddr;
    logic [IDX_W-1:0]  fs_waddr, fs_raddr;
    logic [LINK_W-1:0] link_wdata, link_rdata;
    logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;
    logic [IDX_W-1:0]  fs_wdata, fs_rdata;

    chain_ctl_t        chain_ctl;
    logic [REC_W-1:0]  chain_din, head0, head1;
    logic [IDX_W-1:0]  h0_node, h1_node;
    logic [COUNT_W-1:0] h0_count;
    logic [LINK_W-1:0] h0_links, h1_links;

    logic [KB_W-1:0]   bit_idx, rm_idx;
    logic              kbit, rm_bit, want;
    logic [LINK_W-1:0] cur_links;
    logic [IDX_W-1:0]  pref, alt, child, new_node;
    logic              take_alt;
    logic [IDX_W-1:0]  avail;
    logic [COUNT_W-1:0] dec_count;

    assign {h0_node, h0_count, h0_links} = head0;
    assign h1_node  = head1[REC_W-1 -: IDX_W];
    assign h1_links = head1[LINK_W-1:0];
    assign chain_din = {npend_reg, cnt_rdata, link_rdata};

    // Level select for walk, allocation and removal
    assign bit_idx  = KB_W'(cnt_reg - 1'b1);
    assign rm_idx   = KB_W'(LVL_W'(VALUE_BITS) - depth_reg);
    assign kbit     = key_reg[bit_idx];
    assign rm_bit   = key_reg[rm_idx];
    assign cur_links = at_root_reg ? root_reg : link_rdata;
    assign want     = (kind_reg == KIND_QUERY) ? ~kbit : kbit;
    assign pref     = side_of(cur_links, want);
    assign alt      = side_of(cur_links, kbit);
    assign take_alt = (kind_reg == KIND_QUERY) && (pref == '0);
    assign child    = take_alt ? alt : pref;
    assign new_node = (ftop_reg != '0) ? fs_rdata : nunused_reg[IDX_W-1:0];
    assign avail    = NODE_LAST - used_reg;
    assign dec_count = h0_count - 1'b1;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        key_next     = key_reg;
        root_next    = root_reg;
        at_root_next = at_root_reg;
        pend_next    = pend_reg;
        npend_next   = npend_reg;
        cnt_next     = cnt_reg;
        depth_next   = depth_reg;
        sat_next     = sat_reg;
        res_next     = res_reg;
        status_next  = status_reg;
        parent_next  = parent_reg;
        proot_next   = proot_reg;
        park_next    = park_reg;
        ftop_next    = ftop_reg;
        nunused_next = nunused_reg;
        used_next    = used_reg;
        link_we      = 1'b0;
        link_waddr   = parent_reg;
        link_wdata   = '0;
        link_raddr   = child;
        cnt_we       = 1'b0;
        cnt_waddr    = h0_node;
        cnt_wdata    = '0;
        cnt_raddr    = child;
        fs_we        = 1'b0;
        fs_waddr     = ftop_reg;
        fs_wdata     = h0_node;
        fs_raddr     = ftop_reg - 1'b1;
        chain_ctl    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    kind_next    = item.kind;
                    key_next     = item.key_value;
                    res_next     = '0;
                    status_next  = ST_OK;
                    sat_next     = 1'b0;
                    depth_next   = '0;
                    cnt_next     = LVL_W'(VALUE_BITS);
                    at_root_next = 1'b1;
                    pend_next    = 1'b0;
                    if (item.kind == KIND_INSERT || item.kind == KIND_REMOVE ||
                        item.kind == KIND_QUERY)
                    begin
                        state_next = S_WALK;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_WALK:
            begin
                // Record the node whose links and count just arrived
                if (pend_reg)
                begin
                    chain_ctl.shift_in = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    if (cnt_rdata == COUNT_LIMIT)
                    begin
                        sat_next = 1'b1;
                    end
                end
                // Descend one level or stop
                if (cnt_reg != '0 && child != '0)
                begin
                    npend_next   = child;
                    pend_next    = 1'b1;
                    at_root_next = 1'b0;
                    cnt_next     = cnt_reg - 1'b1;
                    if (kind_reg == KIND_QUERY && !take_alt)
                    begin
                        res_next[bit_idx] = 1'b1;
                    end
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_EVAL;
                end
            end

            S_EVAL:
            begin
                state_next = S_DONE;
                if (kind_reg == KIND_INSERT)
                begin
                    if ((IDX_W+1)'(cnt_reg) > (IDX_W+1)'(avail))
                    begin
                        status_next = ST_NO_NODE;
                    end
                    else if (sat_reg)
                    begin
                        status_next = ST_COUNT_FULL;
                    end
                    else
                    begin
                        park_next   = (depth_reg == '0) ? root_reg : h0_links;
                        parent_next = h0_node;
                        proot_next  = (depth_reg == '0);
                        state_next  = S_INS_CNT;
                    end
                end
                else if (kind_reg == KIND_REMOVE)
                begin
                    if (cnt_reg != '0)
                    begin
                        status_next = ST_ABSENT;
                    end
                    else
                    begin
                        state_next = S_REM_POP;
                    end
                end
            end

            S_INS_CNT:
            begin
                // Bump counts along the existing path, deepest first
                if (depth_reg != '0)
                begin
                    cnt_we     = 1'b1;
                    cnt_waddr  = h0_node;
                    cnt_wdata  = h0_count + 1'b1;
                    chain_ctl.shift_out = 1'b1;
                    depth_next = depth_reg - 1'b1;
                end
                else if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ALLOC_RD;
                end
            end

            S_ALLOC_RD:
            begin
                state_next = S_ALLOC_WR;
            end

            S_ALLOC_WR:
            begin
                // Hand out a node and link it below the parent
                if (ftop_reg != '0)
                begin
                    ftop_next = ftop_reg - 1'b1;
                end
                else
                begin
                    nunused_next = nunused_reg + 1'b1;
                end
                used_next = used_reg + 1'b1;
                cnt_we    = 1'b1;
                cnt_waddr = new_node;
                cnt_wdata = COUNT_W'(1);
                if (proot_reg)
                begin
                    root_next = set_side(park_reg, kbit, new_node);
                end
                else
                begin
                    link_we    = 1'b1;
                    link_waddr = parent_reg;
                    link_wdata = set_side(park_reg, kbit, new_node);
                end
                parent_next = new_node;
                proot_next  = 1'b0;
                park_next   = '0;
                cnt_next    = cnt_reg - 1'b1;
                state_next  = (cnt_reg == LVL_W'(1)) ? S_LEAF : S_ALLOC_RD;
            end

            S_LEAF:
            begin
                link_we    = 1'b1;
                link_waddr = parent_reg;
                link_wdata = '0;
                state_next = S_DONE;
            end

            S_REM_POP:
            begin
                // Drop counts deepest first, free and unlink emptied nodes
                if (depth_reg != '0)
                begin
                    cnt_we    = 1'b1;
                    cnt_waddr = h0_node;
                    cnt_wdata = dec_count;
                    if (dec_count == '0)
                    begin
                        fs_we     = 1'b1;
                        fs_waddr  = ftop_reg;
                        fs_wdata  = h0_node;
                        ftop_next = ftop_reg + 1'b1;
                        used_next = used_reg - 1'b1;
                        if (depth_reg == LVL_W'(1))
                        begin
                            root_next = set_side(root_reg, rm_bit, '0);
                        end
                        else
                        begin
                            link_we    = 1'b1;
                            link_waddr = h1_node;
                            link_wdata = set_side(h1_links, rm_bit, '0);
                        end
                    end
                    chain_ctl.shift_out = 1'b1;
                    depth_next = depth_reg - 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            root_reg    <= '0;
            ftop_reg    <= '0;
            nunused_reg <= (IDX_W+1)'(1);
            used_reg    <= '0;
            at_root_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            root_reg    <= root_next;
            ftop_reg    <= ftop_next;
            nunused_reg <= nunused_next;
            used_reg    <= used_next;
            at_root_reg <= at_root_next;
            pend_reg    <= pend_next;
        end
    end

    // Working registers of the current item
    always_ff @(posedge clk)
    begin
        kind_reg   <= kind_next;
        key_reg    <= key_next;
        npend_reg  <= npend_next;
        cnt_reg    <= cnt_next;
        depth_reg  <= depth_next;
        sat_reg    <= sat_next;
        res_reg    <= res_next;
        status_reg <= status_next;
        parent_reg <= parent_next;
        proot_reg  <= proot_next;
        park_reg   <= park_next;
    end

    btmx_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_links (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    btmx_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_NODES)) u_counts (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    btmx_ram #(.WIDTH(IDX_W), .DEPTH(MAX_NODES)) u_free (
        .clk   (clk),
        .we    (fs_we),
        .waddr (fs_waddr),
        .wdata (fs_wdata),
        .raddr (fs_raddr),
        .rdata (fs_rdata)
    );

    btmx_chain #(.DEPTH(VALUE_BITS), .REC_W(REC_W)) u_path (
        .clk   (clk),
        .ctl   (chain_ctl),
        .din   (chain_din),
        .head0 (head0),
        .head1 (head1)
    );

    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign result.max_xor = res_reg;
    assign result.status  = status_reg;

endmodule

// ===== design/btmx_checker.sv =====
module btmx_checker
    import btmx_pkg::*;
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input item_t   item,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // A result only ends an item in progress
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without an item in progress");

    // After the result the block is free again
    a_done_free: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy && !done)
        else $error("block still busy after its result");

    // An accepted item makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not start work");

    // A nonzero maximum is only reported with an OK status
    a_result_form: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.max_xor == '0 || result.status == ST_OK))
        else $error("nonzero maximum with an error status");

endmodule

bind binary_trie_max_xor_top btmx_checker u_chk (.*);
